@@ rtl/sps_pkg.sv @@
// Shared widths, default page geometry, operation kinds and status codes of the slotted page record store.
package sps_pkg;

    localparam int KIND_W     = 2;
    localparam int SLOT_IDX_W = 10;
    localparam int LEN_W      = 13;
    localparam int BIDX_W     = 12;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 11;

    localparam int DEF_PAGE_BYTES   = 4096;
    localparam int DEF_HEADER_BYTES = 24;
    localparam int DEF_SLOT_BYTES   = 4;
    localparam int DEF_MAX_SLOTS    = 1024;

    localparam logic [KIND_W-1:0] KIND_INIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BEYOND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd5;

endpackage

@@ rtl/sps_if.sv @@
// Valid/ready channel interfaces for request and result words.
interface sps_in_if;
    import sps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [LEN_W-1:0]      record_length;
    logic [BIDX_W-1:0]     byte_index;
    logic [BYTE_W-1:0]     data_byte;
    modport source (output valid, kind, slot_index, record_length, byte_index, data_byte,
                    input ready);
    modport sink (input valid, kind, slot_index, record_length, byte_index, data_byte,
                  output ready);
endinterface

interface sps_out_if;
    import sps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_assigned;
    logic [LEN_W-1:0]      length_out;
    logic [BYTE_W-1:0]     data_out;
    logic [COUNT_W-1:0]    records_live;
    logic [LEN_W-1:0]      free_bytes;
    logic [COUNT_W-1:0]    slots_used;
    modport source (output valid, status, slot_assigned, length_out, data_out,
                    records_live, free_bytes, slots_used, input ready);
    modport sink (input valid, status, slot_assigned, length_out, data_out,
                  records_live, free_bytes, slots_used, output ready);
endinterface

@@ rtl/sps_page_ram.sv @@
// Byte-wide page memory with one write port and one registered read port.
module sps_page_ram #(
    parameter int PAGE_BYTES = sps_pkg::DEF_PAGE_BYTES
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(PAGE_BYTES)-1:0] waddr,
    input  logic [sps_pkg::BYTE_W-1:0]    wdata,
    input  logic [$clog2(PAGE_BYTES)-1:0] raddr,
    output logic [sps_pkg::BYTE_W-1:0]    rdata
);
    import sps_pkg::*;

    logic [BYTE_W-1:0] mem [PAGE_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/slotted_page_record_store.sv @@
// Slotted page record store: slot directory and page byte memory under one sequencer.
// Init, range errors, refused and dropped words, and later insert bytes outside the directory
// are answered straight from the request; other deletes, later insert bytes and reads that end
// deleted or beyond record take a directory read; a read that returns a byte adds a page read; a
// first insert byte allocates directly on append, or scans up to the lowest deleted slot k.
// Throughput: one word at a time, taken the cycle after the previous result is delivered.
// Reset (rst_n, asynchronous, active low) empties the page; the memories are not cleared.
module slotted_page_record_store #(
    parameter int PAGE_BYTES   = sps_pkg::DEF_PAGE_BYTES,
    parameter int HEADER_BYTES = sps_pkg::DEF_HEADER_BYTES,
    parameter int SLOT_BYTES   = sps_pkg::DEF_SLOT_BYTES,
    parameter int MAX_SLOTS    = sps_pkg::DEF_MAX_SLOTS
) (
    input  logic      clk,
    input  logic      rst_n,
    sps_in_if.sink    in_ch,
    sps_out_if.source out_ch
);
    import sps_pkg::*;

    // Page addresses, page-edge pointers (which can equal PAGE_BYTES), slot indexes
    // and slot counts (which can equal MAX_SLOTS).
    localparam int AW = $clog2(PAGE_BYTES);
    localparam int EW = AW + 1;
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = SW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_WAIT,
        S_SCAN_CHK,
        S_ALLOC,
        S_SLOT_WAIT,
        S_SLOT_CHK,
        S_PAGE_WAIT,
        S_PAGE_CHK
    } state_t;

    state_t state_reg, state_next;

    // Captured request word.
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [LEN_W-1:0]      rlen_reg, rlen_next;
    logic [BIDX_W-1:0]     bidx_reg, bidx_next;
    logic [BYTE_W-1:0]     dbyte_reg, dbyte_next;

    // Page header state.
    logic [CW-1:0] dir_count_reg, dir_count_next;
    logic [CW-1:0] live_count_reg, live_count_next;
    logic [EW-1:0] free_begin_reg, free_begin_next;
    logic [EW-1:0] free_end_reg, free_end_next;
    logic [SW-1:0] insert_slot_reg, insert_slot_next;
    logic          refused_reg, refused_next;

    // Sequencer working registers. slot_sel addresses both slot memories and, during
    // the free-slot scan, serves as the scan index.
    logic [SW-1:0] slot_sel_reg, slot_sel_next;
    logic          append_reg, append_next;
    logic [AW-1:0] page_addr_reg, page_addr_next;

    // Result word registers.
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_IDX_W-1:0] assigned_reg, assigned_next;
    logic [LEN_W-1:0]      len_out_reg, len_out_next;
    logic [BYTE_W-1:0]     data_out_reg, data_out_next;

    // Slot directory memories; a length of zero marks a deleted slot.
    logic [LEN_W-1:0] slot_len_mem [MAX_SLOTS];
    logic [AW-1:0]    slot_off_mem [MAX_SLOTS];
    logic [LEN_W-1:0] len_q;
    logic [AW-1:0]    off_q;
    logic             slot_we;
    logic [LEN_W-1:0] slot_wlen;
    logic [AW-1:0]    slot_woff;

    logic              page_we;
    logic [AW-1:0]     page_waddr;
    logic [BYTE_W-1:0] page_rdata;

    logic        accept;
    logic [31:0] gap32;
    logic [31:0] need32;
    logic [31:0] addr32;
    logic [EW-1:0] end_after;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;

    // The gap between the directory end and the record area, never negative.
    assign gap32 = (free_end_reg > free_begin_reg) ? 32'(free_end_reg - free_begin_reg) : 32'd0;
    // Space a first byte needs: the record itself, plus a directory entry when appending.
    assign need32 = 32'(rlen_reg) + (append_reg ? 32'(SLOT_BYTES) : 32'd0);
    // Page address of the requested byte of the slot just read from the directory.
    assign addr32 = 32'(off_q) + 32'(bidx_reg);
    assign end_after = free_end_reg - EW'(rlen_reg);

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_len_mem[slot_sel_reg] <= slot_wlen;
            slot_off_mem[slot_sel_reg] <= slot_woff;
        end
        len_q <= slot_len_mem[slot_sel_reg];
        off_q <= slot_off_mem[slot_sel_reg];
    end

    sps_page_ram #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (dbyte_reg),
        .raddr (page_addr_reg),
        .rdata (page_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        rlen_next        = rlen_reg;
        bidx_next        = bidx_reg;
        dbyte_next       = dbyte_reg;
        dir_count_next   = dir_count_reg;
        live_count_next  = live_count_reg;
        free_begin_next  = free_begin_reg;
        free_end_next    = free_end_reg;
        insert_slot_next = insert_slot_reg;
        refused_next     = refused_reg;
        slot_sel_next    = slot_sel_reg;
        append_next      = append_reg;
        page_addr_next   = page_addr_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        assigned_next    = assigned_reg;
        len_out_next     = len_out_reg;
        data_out_next    = data_out_reg;
        slot_we          = 1'b0;
        slot_wlen        = '0;
        slot_woff        = '0;
        page_we          = 1'b0;
        page_waddr       = '0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next     = in_ch.kind;
                    rlen_next     = in_ch.record_length;
                    bidx_next     = in_ch.byte_index;
                    dbyte_next    = in_ch.data_byte;
                    status_next   = ST_OK;
                    assigned_next = '0;
                    len_out_next  = '0;
                    data_out_next = '0;
                    case (in_ch.kind)
                        KIND_INIT:
                        begin
                            dir_count_next  = '0;
                            live_count_next = '0;
                            free_begin_next = EW'(HEADER_BYTES);
                            free_end_next   = EW'(PAGE_BYTES);
                            refused_next    = 1'b0;
                            out_valid_next  = 1'b1;
                        end
                        KIND_INSERT:
                        begin
                            if (in_ch.byte_index == '0)
                            begin
                                // A new record always starts on its first byte.
                                if (in_ch.record_length == '0)
                                begin
                                    status_next    = ST_BEYOND;
                                    refused_next   = 1'b1;
                                    out_valid_next = 1'b1;
                                end
                                else if (live_count_reg != dir_count_reg)
                                begin
                                    // Some directory entry is deleted: scan for the lowest.
                                    append_next   = 1'b0;
                                    slot_sel_next = '0;
                                    state_next    = S_SCAN_WAIT;
                                end
                                else if (32'(dir_count_reg) >= 32'(MAX_SLOTS))
                                begin
                                    status_next    = ST_FULL;
                                    refused_next   = 1'b1;
                                    out_valid_next = 1'b1;
                                end
                                else
                                begin
                                    append_next   = 1'b1;
                                    slot_sel_next = SW'(dir_count_reg);
                                    state_next    = S_ALLOC;
                                end
                            end
                            else if (refused_reg)
                            begin
                                status_next    = ST_DROPPED;
                                out_valid_next = 1'b1;
                            end
                            else if (32'(insert_slot_reg) >= 32'(dir_count_reg))
                            begin
                                status_next    = ST_BEYOND;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                slot_sel_next = insert_slot_reg;
                                state_next    = S_SLOT_WAIT;
                            end
                        end
                        default:
                        begin
                            // Delete and read both start with a directory lookup.
                            if ((32'(in_ch.slot_index) >= 32'(dir_count_reg)) ||
                                (32'(in_ch.slot_index) >= 32'(MAX_SLOTS)))
                            begin
                                status_next    = ST_RANGE;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                slot_sel_next = SW'(in_ch.slot_index);
                                state_next    = S_SLOT_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_SCAN_WAIT:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                // A deleted slot is known to exist below dir_count, so the scan ends.
                if (len_q == '0)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    slot_sel_next = slot_sel_reg + SW'(1);
                    state_next    = S_SCAN_WAIT;
                end
            end
            S_ALLOC:
            begin
                if (gap32 < need32)
                begin
                    status_next  = ST_FULL;
                    refused_next = 1'b1;
                end
                else
                begin
                    // Records grow down from the page end; the first byte lands at the new end.
                    free_end_next = end_after;
                    if (append_reg)
                    begin
                        dir_count_next  = dir_count_reg + CW'(1);
                        free_begin_next = free_begin_reg + EW'(SLOT_BYTES);
                    end
                    slot_we          = 1'b1;
                    slot_wlen        = rlen_reg;
                    slot_woff        = AW'(end_after);
                    live_count_next  = live_count_reg + CW'(1);
                    insert_slot_next = slot_sel_reg;
                    refused_next     = 1'b0;
                    page_we          = 1'b1;
                    page_waddr       = AW'(end_after);
                    assigned_next    = SLOT_IDX_W'(slot_sel_reg);
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_SLOT_WAIT:
            begin
                state_next = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                if (kind_reg == KIND_INSERT)
                begin
                    if (32'(bidx_reg) >= 32'(len_q))
                    begin
                        status_next = ST_BEYOND;
                    end
                    else
                    begin
                        page_we       = (addr32 < 32'(PAGE_BYTES));
                        page_waddr    = AW'(addr32);
                        assigned_next = SLOT_IDX_W'(insert_slot_reg);
                    end
                end
                else if (len_q == '0)
                begin
                    status_next = ST_DELETED;
                end
                else if (kind_reg == KIND_DELETE)
                begin
                    slot_we         = 1'b1;
                    live_count_next = live_count_reg - CW'(1);
                end
                else
                begin
                    len_out_next = len_q;
                    if (32'(bidx_reg) >= 32'(len_q))
                    begin
                        status_next = ST_BEYOND;
                    end
                    else if (addr32 < 32'(PAGE_BYTES))
                    begin
                        page_addr_next = AW'(addr32);
                        out_valid_next = out_valid_reg && !out_ch.ready;
                        state_next     = S_PAGE_WAIT;
                    end
                end
            end
            S_PAGE_WAIT:
            begin
                state_next = S_PAGE_CHK;
            end
            S_PAGE_CHK:
            begin
                data_out_next  = page_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            dir_count_reg   <= '0;
            live_count_reg  <= '0;
            free_begin_reg  <= EW'(HEADER_BYTES);
            free_end_reg    <= EW'(PAGE_BYTES);
            insert_slot_reg <= '0;
            refused_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_reg      <= '0;
            assigned_reg    <= '0;
            len_out_reg     <= '0;
            data_out_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            dir_count_reg   <= dir_count_next;
            live_count_reg  <= live_count_next;
            free_begin_reg  <= free_begin_next;
            free_end_reg    <= free_end_next;
            insert_slot_reg <= insert_slot_next;
            refused_reg     <= refused_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            assigned_reg    <= assigned_next;
            len_out_reg     <= len_out_next;
            data_out_reg    <= data_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        rlen_reg      <= rlen_next;
        bidx_reg      <= bidx_next;
        dbyte_reg     <= dbyte_next;
        slot_sel_reg  <= slot_sel_next;
        append_reg    <= append_next;
        page_addr_reg <= page_addr_next;
    end

    // The header counters only change while no result is pending, so they feed the
    // result word directly.
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.slot_assigned = assigned_reg;
    assign out_ch.length_out    = len_out_reg;
    assign out_ch.data_out      = data_out_reg;
    assign out_ch.records_live  = COUNT_W'(live_count_reg);
    assign out_ch.free_bytes    = LEN_W'(gap32);
    assign out_ch.slots_used    = COUNT_W'(dir_count_reg);

    // A result is only raised once the sequencer is back at rest.
    a_result_at_rest : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_IDLE))
        else $error("result pending while sequencer busy");

    // The directory never grows past the record area.
    a_gap_order : assert property (@(posedge clk) disable iff (!rst_n)
        free_begin_reg <= free_end_reg)
        else $error("directory overlaps record area");

    // Live records are a subset of directory entries.
    a_live_bound : assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= dir_count_reg)
        else $error("live count exceeds directory size");

    // The directory size stays within its capacity.
    a_dir_bound : assert property (@(posedge clk) disable iff (!rst_n)
        32'(dir_count_reg) <= 32'(MAX_SLOTS))
        else $error("directory size beyond capacity");

endmodule

@@ test/slotted_page_record_store_test.sv @@
// Testbench for the slotted page record store: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module slotted_page_record_store_test;
    import sps_pkg::*;

    localparam int PAGE_SZ   = DEF_PAGE_BYTES;
    localparam int HDR_SZ    = DEF_HEADER_BYTES;
    localparam int SLOT_SZ   = DEF_SLOT_BYTES;
    localparam int SLOT_MAX  = DEF_MAX_SLOTS;
    localparam int CYCLE_CAP = 6000000;

    // One request word and one result word, at the widths of the ports.
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [LEN_W-1:0]      record_length;
        logic [BIDX_W-1:0]     byte_index;
        logic [BYTE_W-1:0]     data_byte;
    } page_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_assigned;
        logic [LEN_W-1:0]      length_out;
        logic [BYTE_W-1:0]     data_out;
        logic [COUNT_W-1:0]    records_live;
        logic [LEN_W-1:0]      free_bytes;
        logic [COUNT_W-1:0]    slots_used;
    } page_resp_t;

    // The scoreboard keeps its own image of the page. Every accepted request word is run
    // through that image, and the answer it gives waits in a queue for the block's result.
    class page_scoreboard;
        logic [7:0] page_mem [PAGE_SZ];
        bit         byte_written [PAGE_SZ];
        int         rec_offset [SLOT_MAX];
        int         rec_length [SLOT_MAX];
        int         dir_n;
        int         live_n;
        int         gap_lo;
        int         gap_hi;
        int         cur_slot;
        bit         cur_refused;
        page_resp_t awaited [$];
        int         errors;
        int         checked;
        int         status_hits [8];

        function new();
            foreach (page_mem[i])
            begin
                page_mem[i] = '0;
                byte_written[i] = 0;
            end
            foreach (rec_length[i])
            begin
                rec_offset[i] = 0;
                rec_length[i] = 0;
            end
            format_page();
            cur_slot = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void format_page();
            dir_n = 0;
            live_n = 0;
            gap_lo = HDR_SZ;
            gap_hi = PAGE_SZ;
            cur_refused = 0;
        endfunction

        function int gap_size();
            return (gap_hi > gap_lo) ? gap_hi - gap_lo : 0;
        endfunction

        function void put_byte(int slot, int pos, logic [7:0] value);
            int addr;
            addr = rec_offset[slot] + pos;
            if (addr < PAGE_SZ)
            begin
                page_mem[addr] = value;
                byte_written[addr] = 1;
            end
        endfunction

        // First byte of an insert: reuse the lowest empty slot, or append one at extra cost.
        function logic [STATUS_W-1:0] open_record(int len, logic [7:0] value);
            int slot;
            int need;
            slot = dir_n;
            need = len;
            if (len == 0)
            begin
                cur_refused = 1;
                return ST_BEYOND;
            end
            for (int i = 0; i < dir_n && i < SLOT_MAX; i++)
            begin
                if (rec_length[i] == 0)
                begin
                    slot = i;
                    break;
                end
            end
            if (slot == dir_n)
            begin
                if (dir_n >= SLOT_MAX)
                begin
                    cur_refused = 1;
                    return ST_FULL;
                end
                need += SLOT_SZ;
            end
            if (gap_size() < need)
            begin
                cur_refused = 1;
                return ST_FULL;
            end
            gap_hi -= len;
            if (slot == dir_n)
            begin
                dir_n++;
                gap_lo += SLOT_SZ;
            end
            rec_offset[slot] = gap_hi;
            rec_length[slot] = len;
            live_n++;
            cur_slot = slot;
            cur_refused = 0;
            put_byte(slot, 0, value);
            return ST_OK;
        endfunction

        function logic [STATUS_W-1:0] append_byte(int pos, logic [7:0] value);
            if (cur_refused)
                return ST_DROPPED;
            if (cur_slot >= dir_n || cur_slot >= SLOT_MAX)
                return ST_BEYOND;
            if (pos >= rec_length[cur_slot])
                return ST_BEYOND;
            put_byte(cur_slot, pos, value);
            return ST_OK;
        endfunction

        function void note_input(page_req_t req);
            page_resp_t exp;
            int sidx;
            int addr;
            exp = '0;
            sidx = int'(req.slot_index);
            if (req.kind == KIND_INIT)
                format_page();
            else if (req.kind == KIND_INSERT)
            begin
                if (req.byte_index == '0)
                    exp.status = open_record(int'(req.record_length), req.data_byte);
                else
                    exp.status = append_byte(int'(req.byte_index), req.data_byte);
                if (exp.status == ST_OK)
                    exp.slot_assigned = SLOT_IDX_W'(cur_slot);
            end
            else if (sidx >= dir_n || sidx >= SLOT_MAX)
                exp.status = ST_RANGE;
            else if (rec_length[sidx] == 0)
                exp.status = ST_DELETED;
            else if (req.kind == KIND_DELETE)
            begin
                rec_length[sidx] = 0;
                rec_offset[sidx] = 0;
                if (live_n > 0)
                    live_n--;
            end
            else
            begin
                exp.length_out = LEN_W'(rec_length[sidx]);
                if (int'(req.byte_index) >= rec_length[sidx])
                    exp.status = ST_BEYOND;
                else
                begin
                    addr = rec_offset[sidx] + int'(req.byte_index);
                    exp.data_out = (addr < PAGE_SZ) ? page_mem[addr] : '0;
                end
            end
            exp.records_live = COUNT_W'(live_n);
            exp.free_bytes = LEN_W'(gap_size());
            exp.slots_used = COUNT_W'(dir_n);
            status_hits[exp.status]++;
            awaited.push_back(exp);
        endfunction

        function void check_result(page_resp_t got);
            page_resp_t exp;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result word %p", $time, got);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (got !== exp)
            begin
                $display("%0t: result mismatch, expected %p, actual %p", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   tx_idle;
    int   rx_idle;

    // Generator view of an insert in flight, so random bytes mostly follow a real record.
    bit   rec_open;
    int   rec_len;
    int   rec_next;

    page_scoreboard sb;

    sps_in_if  in_ch ();
    sps_out_if out_ch ();

    slotted_page_record_store u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop for a hung block; the limit is far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sb.awaited.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver stalls at random, changing its mind only at falling edges.
    always @(negedge clk)
    begin
        out_ch.ready = (int'($urandom_range(99)) >= rx_idle);
    end

    // Results are taken at the rising edge, where valid and ready complete a handshake.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{out_ch.status, out_ch.slot_assigned, out_ch.length_out,
                              out_ch.data_out, out_ch.records_live, out_ch.free_bytes,
                              out_ch.slots_used});
    end

    // Present one word from a falling edge and hold it until it is accepted. The word is
    // noted in the scoreboard at the accepting edge, before the next word is chosen.
    task automatic send_word(page_req_t req);
        in_ch.kind = req.kind;
        in_ch.slot_index = req.slot_index;
        in_ch.record_length = req.record_length;
        in_ch.byte_index = req.byte_index;
        in_ch.data_byte = req.data_byte;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(req);
        @(negedge clk);
        if (int'($urandom_range(99)) < tx_idle)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // A read of a byte that no insert ever stored would see undefined memory. Such a read
    // is pointed at byte 0 instead, which every live record has written.
    function automatic page_req_t guard_read(page_req_t req);
        int sidx;
        sidx = int'(req.slot_index);
        if (req.kind == KIND_READ && sidx < sb.dir_n && sb.rec_length[sidx] != 0 &&
            int'(req.byte_index) < sb.rec_length[sidx] &&
            !sb.byte_written[sb.rec_offset[sidx] + int'(req.byte_index)])
            req.byte_index = '0;
        return req;
    endfunction

    task automatic send_checked(page_req_t req);
        send_word(guard_read(req));
    endtask

    task automatic send_insert(int len, int pos, logic [7:0] value);
        page_req_t req;
        req = '0;
        req.kind = KIND_INSERT;
        req.record_length = LEN_W'(len);
        req.byte_index = BIDX_W'(pos);
        req.data_byte = value;
        send_word(req);
    endtask

    task automatic send_access(logic [KIND_W-1:0] kind, int slot, int pos);
        page_req_t req;
        req = '0;
        req.kind = kind;
        req.slot_index = SLOT_IDX_W'(slot);
        req.byte_index = BIDX_W'(pos);
        send_checked(req);
    endtask

    // Mostly well-formed traffic: records written byte by byte, with reads and deletes on
    // slots near the directory, plus a share of fully random words as noise.
    function automatic page_req_t pick_word();
        page_req_t req;
        int roll;
        int lim;
        logic [63:0] noise;
        req = '0;
        req.data_byte = BYTE_W'($urandom_range(255));
        roll = $urandom_range(99);
        if (rec_open && roll < 60)
        begin
            req.kind = KIND_INSERT;
            req.record_length = LEN_W'($urandom_range(8191));
            req.byte_index = BIDX_W'(rec_next);
            rec_next++;
            if (rec_next >= rec_len || $urandom_range(19) == 0)
                rec_open = 0;
            return req;
        end
        roll = $urandom_range(99);
        lim = sb.dir_n + 2;
        if (lim > SLOT_MAX)
            lim = SLOT_MAX;
        if (roll < 35)
        begin
            req.kind = KIND_INSERT;
            roll = $urandom_range(99);
            if (roll < 70)
                rec_len = $urandom_range(1, 6);
            else if (roll < 92)
                rec_len = $urandom_range(7, 64);
            else
                rec_len = $urandom_range(65, 4096);
            req.record_length = LEN_W'(rec_len);
            rec_open = (rec_len > 1);
            rec_next = 1;
        end
        else if (roll < 65)
        begin
            req.kind = KIND_READ;
            req.slot_index = SLOT_IDX_W'($urandom_range(lim - 1));
            req.byte_index = BIDX_W'($urandom_range(7));
        end
        else if (roll < 80)
        begin
            req.kind = KIND_DELETE;
            req.slot_index = SLOT_IDX_W'($urandom_range(lim - 1));
        end
        else if (roll < 83)
        begin
            req.kind = KIND_INIT;
            rec_open = 0;
        end
        else
        begin
            noise = {$urandom, $urandom};
            req = noise[$bits(page_req_t)-1:0];
            if (req.kind == KIND_INSERT && req.byte_index == '0)
                rec_open = 0;
        end
        return guard_read(req);
    endfunction

    task automatic run_phase(int words, int tx_pct, int rx_pct);
        tx_idle = tx_pct;
        rx_idle = rx_pct;
        repeat (words) send_word(pick_word());
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        tx_idle = 35;
        rx_idle = 69;
        rec_open = 0;
        rec_len = 0;
        rec_next = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_INIT;
        in_ch.slot_index = '0;
        in_ch.record_length = '0;
        in_ch.byte_index = '0;
        in_ch.data_byte = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed opening: empty page, refusals, a full record, the deleted cases,
        // slot reuse, a page-sized refusal and a stray byte after re-formatting.
        send_access(KIND_READ, 0, 0);
        send_access(KIND_DELETE, SLOT_MAX - 1, 0);
        send_insert(0, 0, 8'h11);
        send_insert(5, 1, 8'h22);
        send_insert(3, 0, 8'h00);
        send_insert(3, 1, 8'hFF);
        send_insert(3, 2, 8'h5A);
        send_insert(3, 3, 8'h77);
        send_access(KIND_READ, 0, 0);
        send_access(KIND_READ, 0, 1);
        send_access(KIND_READ, 0, 2);
        send_access(KIND_READ, 0, 4095);
        send_insert(2, 0, 8'hA5);
        send_access(KIND_DELETE, 0, 0);
        send_access(KIND_DELETE, 0, 0);
        send_access(KIND_READ, 0, 0);
        send_insert(1, 0, 8'h3C);
        send_access(KIND_READ, 0, 0);
        send_insert(4096, 0, 8'hC3);
        send_insert(4096, 4095, 8'h01);
        send_access(KIND_READ, 1, 1);
        send_access(KIND_INIT, 0, 0);
        send_insert(1, 1, 8'h80);
        send_access(KIND_READ, 0, 0);
        send_insert(4072, 0, 8'hE7);

        // Random traffic in three idling phases: receiver-heavy, sender-heavy, then none.
        run_phase(180, 35, 69);
        run_phase(175, 69, 35);
        run_phase(170, 0, 0);
        in_ch.valid = 1'b0;

        // Drain: every expected result must arrive, then a short quiet period.
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Checked %0d results: ok %0d, full %0d, range %0d, deleted %0d,",
                 sb.checked, sb.status_hits[ST_OK], sb.status_hits[ST_FULL],
                 sb.status_hits[ST_RANGE], sb.status_hits[ST_DELETED]);
        $display("beyond %0d, dropped %0d; %0d mismatches in %0d cycles",
                 sb.status_hits[ST_BEYOND], sb.status_hits[ST_DROPPED], sb.errors,
                 cycle_count);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ slotted_page_record_store.f @@
rtl/sps_pkg.sv
rtl/sps_if.sv
rtl/sps_page_ram.sv
rtl/slotted_page_record_store.sv
test/slotted_page_record_store_test.sv
